### sv/tcsnk_pkg.sv
// Package for the Type-C try-sink role controller.
// Holds role codes, register indexes, reset values and the shared state types.
`default_nettype none
package tcsnk_pkg;

  localparam int TimerBits = 12;

  localparam int RoleW   = 3;
  localparam int HitsW   = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;

  localparam logic [RoleW-1:0] S_IDLE  = 3'd0;
  localparam logic [RoleW-1:0] S_UNSNK = 3'd1;
  localparam logic [RoleW-1:0] S_AWSNK = 3'd2;
  localparam logic [RoleW-1:0] S_ATSNK = 3'd3;
  localparam logic [RoleW-1:0] S_UNSRC = 3'd4;
  localparam logic [RoleW-1:0] S_ATSRC = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_LIMIT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POWER_ON_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TRY_SINK_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WAIT_SINK_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SINK_TO_SRC_TICKS = 3'd4;

  localparam logic [4:0]  RST_DEBOUNCE_LIMIT    = 5'd15;
  localparam logic [7:0]  RST_POWER_ON_TICKS    = 8'd4;
  localparam logic [11:0] RST_TRY_SINK_TICKS    = 12'd1000;
  localparam logic [11:0] RST_WAIT_SINK_TICKS   = 12'd400;
  localparam logic [11:0] RST_SINK_TO_SRC_TICKS = 12'd2000;

  typedef logic [TimerBits-1:0] timer_t;

  typedef struct packed {
    logic [4:0]  debounce_limit;
    logic [7:0]  power_on_ticks;
    logic [11:0] try_sink_ticks;
    logic [11:0] wait_sink_ticks;
    logic [11:0] sink_to_src_ticks;
  } cfg_t;

  typedef struct packed {
    logic [RoleW-1:0]         role;
    timer_t                   timer_left;
    logic                     timer_running;
    logic [1:0][HitsW-1:0]    cc_hits;
    logic                     connected;
    logic                     cc2_flag;
    logic                     tried_sink;
    logic                     in_swap;
    logic [1:0]               armed_mask;
    logic                     dir_below;
  } state_t;

  typedef struct packed {
    logic             op;
    logic [1:0]       cmp_channel;
    logic             sink_present;
    logic             swap_done;
    logic             swap_primary;
  } item_t;

  typedef struct packed {
    logic [RoleW-1:0] role_state;
    logic             rd_on;
    logic             rp_on;
    logic [1:0]       cmp_armed;
    logic             cmp_below;
    logic             cc2_active;
    logic             pd_start;
    logic             stay_awake;
  } result_t;

endpackage
`default_nettype wire

### sv/tcsnk_if.sv
// Valid/ready channel interfaces for the role controller input and result beats.
// No dependencies.
`default_nettype none
interface tcsnk_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [1:0] cmp_channel;
  logic       sink_present;
  logic       swap_done;
  logic       swap_primary;

  modport source (output valid, op, cmp_channel, sink_present, swap_done, swap_primary,
                  input ready);
  modport sink (input valid, op, cmp_channel, sink_present, swap_done, swap_primary,
                output ready);
endinterface

interface tcsnk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] role_state;
  logic       rd_on;
  logic       rp_on;
  logic [1:0] cmp_armed;
  logic       cmp_below;
  logic       cc2_active;
  logic       pd_start;
  logic       stay_awake;

  modport source (output valid, role_state, rd_on, rp_on, cmp_armed, cmp_below,
                  cc2_active, pd_start, stay_awake, input ready);
  modport sink (input valid, role_state, rd_on, rp_on, cmp_armed, cmp_below,
                cc2_active, pd_start, stay_awake, output ready);
endinterface
`default_nettype wire

### sv/tcsnk_cfg_regs.sv
// Configuration register file of the role controller.
// Depends on tcsnk_pkg.
`default_nettype none
module tcsnk_cfg_regs
  import tcsnk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit    <= RST_DEBOUNCE_LIMIT;
      cfg_q.power_on_ticks    <= RST_POWER_ON_TICKS;
      cfg_q.try_sink_ticks    <= RST_TRY_SINK_TICKS;
      cfg_q.wait_sink_ticks   <= RST_WAIT_SINK_TICKS;
      cfg_q.sink_to_src_ticks <= RST_SINK_TO_SRC_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_LIMIT:    cfg_q.debounce_limit    <= cfg_data_i[4:0];
        REG_POWER_ON_TICKS:    cfg_q.power_on_ticks    <= cfg_data_i[7:0];
        REG_TRY_SINK_TICKS:    cfg_q.try_sink_ticks    <= cfg_data_i[11:0];
        REG_WAIT_SINK_TICKS:   cfg_q.wait_sink_ticks   <= cfg_data_i[11:0];
        REG_SINK_TO_SRC_TICKS: cfg_q.sink_to_src_ticks <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### sv/tcsnk_step.sv
// Next-state and result logic for one beat: timer, role rules, entry actions, debounce.
// Depends on tcsnk_pkg.
`default_nettype none
module tcsnk_step
  import tcsnk_pkg::*;
(
  input  wire state_t  state_i,
  input  wire cfg_t    cfg_i,
  input  wire item_t   item_i,
  output state_t       state_o,
  output result_t      result_o
);

  always_comb begin
    state_t           n;
    logic [RoleW-1:0] nxt;
    logic             expired;
    logic             entered;
    logic             pd;
    logic             idx;
    logic [HitsW-1:0] hits;

    n       = state_i;
    nxt     = state_i.role;
    expired = 1'b0;
    entered = 1'b0;
    pd      = 1'b0;
    idx     = item_i.cmp_channel[0];
    hits    = '0;

    if (item_i.op) begin
      if (item_i.cmp_channel[1]) begin
        hits = HitsW'(state_i.cc_hits[idx] + 1'b1);
        if (hits > cfg_i.debounce_limit) begin
          hits        = '0;
          n.connected = !state_i.connected;
          n.cc2_flag  = idx;
        end
        n.cc_hits[idx]    = hits;
        n.dir_below       = n.connected;
        n.armed_mask[idx] = 1'b1;
      end
    end else begin
      if (state_i.timer_running && (state_i.timer_left != '0)) begin
        n.timer_left = state_i.timer_left - 1'b1;
      end
      expired = state_i.timer_running && (n.timer_left == '0);

      case (state_i.role)
        S_IDLE: begin
          if (expired) begin
            n.timer_running = 1'b0;
            n.armed_mask    = '0;
            nxt             = S_UNSRC;
          end
        end
        S_UNSNK: begin
          n.cc_hits       = '0;
          n.connected     = 1'b0;
          n.dir_below     = 1'b0;
          n.armed_mask    = 2'b11;
          n.timer_left    = TimerBits'(cfg_i.try_sink_ticks);
          n.timer_running = 1'b1;
          nxt             = S_AWSNK;
        end
        S_AWSNK: begin
          if (expired) begin
            n.tried_sink = 1'b1;
            nxt          = S_UNSRC;
          end
          if (state_i.connected) nxt = S_ATSNK;
          if (nxt != S_AWSNK) n.timer_running = 1'b0;
        end
        S_ATSNK: begin
          if (item_i.swap_done) begin
            n.armed_mask = '0;
            nxt          = S_ATSRC;
          end
          if (!state_i.in_swap && item_i.swap_primary) n.in_swap = 1'b1;
          if (!state_i.connected && !n.in_swap) nxt = S_UNSRC;
          if (expired) begin
            n.tried_sink = 1'b1;
            nxt          = S_UNSRC;
          end
          if (nxt != S_ATSNK) n.timer_running = 1'b0;
        end
        S_UNSRC: begin
          if (expired) n.tried_sink = 1'b0;
          if (item_i.sink_present) nxt = n.tried_sink ? S_ATSRC : S_UNSNK;
          if (nxt != S_UNSRC) n.timer_running = 1'b0;
        end
        S_ATSRC: begin
          if (!item_i.sink_present) nxt = S_UNSRC;
        end
        default: ;
      endcase

      if (nxt != state_i.role) begin
        entered = 1'b1;
        n.role  = nxt;
        case (nxt)
          S_ATSNK: begin
            n.timer_left    = TimerBits'(cfg_i.sink_to_src_ticks);
            n.timer_running = 1'b1;
            n.in_swap       = 1'b0;
            pd              = 1'b1;
          end
          S_UNSRC: begin
            n.armed_mask = '0;
            if (n.tried_sink) begin
              n.timer_left    = TimerBits'(cfg_i.wait_sink_ticks);
              n.timer_running = 1'b1;
            end
          end
          S_ATSRC: n.tried_sink = 1'b0;
          default: ;
        endcase
      end
    end

    state_o             = n;
    result_o.role_state = n.role;
    result_o.rd_on      = (n.role == S_UNSNK) || (n.role == S_AWSNK) || (n.role == S_ATSNK);
    result_o.rp_on      = (n.role == S_UNSRC) || (n.role == S_ATSRC);
    result_o.cmp_armed  = n.armed_mask;
    result_o.cmp_below  = n.dir_below;
    result_o.cc2_active = n.cc2_flag;
    result_o.pd_start   = pd;
    result_o.stay_awake = entered || (n.role < S_UNSRC);
  end

endmodule
`default_nettype wire

### sv/typec_try_sink_role_fsm.sv
// Type-C dual-role port controller with try-sink; top level.
// Each accepted input beat has its result registered in the output register.
// Throughput: one beat per cycle unless out_o stalls; role step: one pass state to state.
// Reset: idle role, timer loaded with the power-on count and running, config at defaults.
// Depends on tcsnk_pkg, tcsnk_if, tcsnk_cfg_regs and tcsnk_step.
`default_nettype none
module typec_try_sink_role_fsm
  import tcsnk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  tcsnk_in_if.sink                in_i,
  tcsnk_out_if.source             out_o
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  item_t   item;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    accept;

  tcsnk_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign item.op           = in_i.op;
  assign item.cmp_channel  = in_i.cmp_channel;
  assign item.sink_present = in_i.sink_present;
  assign item.swap_done    = in_i.swap_done;
  assign item.swap_primary = in_i.swap_primary;

  tcsnk_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.role          <= S_IDLE;
      state_q.timer_left    <= TimerBits'(RST_POWER_ON_TICKS);
      state_q.timer_running <= 1'b1;
      state_q.cc_hits       <= '0;
      state_q.connected     <= 1'b0;
      state_q.cc2_flag      <= 1'b0;
      state_q.tried_sink    <= 1'b0;
      state_q.in_swap       <= 1'b0;
      state_q.armed_mask    <= '0;
      state_q.dir_below     <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.role_state = res_q.role_state;
  assign out_o.rd_on      = res_q.rd_on;
  assign out_o.rp_on      = res_q.rp_on;
  assign out_o.cmp_armed  = res_q.cmp_armed;
  assign out_o.cmp_below  = res_q.cmp_below;
  assign out_o.cc2_active = res_q.cc2_active;
  assign out_o.pd_start   = res_q.pd_start;
  assign out_o.stay_awake = res_q.stay_awake;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Type-C try-sink role controller: queues tick and
// comparator beats, predicts each result beat from its own role model and checks it.
// Depends on tcsnk_pkg, tcsnk_if and typec_try_sink_role_fsm.
module tb;
  import tcsnk_pkg::*;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMP  = 1'b1;

  localparam logic [1:0] CH_OFF0 = 2'd0;
  localparam logic [1:0] CH_OFF1 = 2'd1;
  localparam logic [1:0] CH_CC1  = 2'd2;
  localparam logic [1:0] CH_CC2  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd5;

  localparam int HOLD_CYCLES     = 400;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int BEATS_PER_PHASE = 250;
  localparam int GRACE_CYCLES    = 4;
  localparam int PRINT_CAP       = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CfgW-1:0]      cfg_data;

  tcsnk_in_if  in_if ();
  tcsnk_out_if out_if ();

  typec_try_sink_role_fsm u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // role model state
  cfg_t             cfg_shadow;
  logic [RoleW-1:0] role_now;
  timer_t           tmr_left;
  logic             tmr_on;
  logic [HitsW-1:0] cc_count [2];
  logic             link_up;
  logic             on_cc2;
  logic             sink_tried;
  logic             swapping;
  logic [1:0]       arm_mask;
  logic             watch_below;

  item_t   beat_q [$];
  result_t expect_q [$];
  item_t   offer_beat;

  int n_pushed;
  int n_checked;
  int errors;
  int n_settings;
  int snk_attaches;
  int src_attaches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int cyc;
    for (cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d of %0d beats checked", cyc, n_checked, n_pushed);
    $display("FAILURE");
    $finish;
  end

  function automatic result_t role_step(item_t it);
    result_t          r;
    logic [RoleW-1:0] nxt;
    logic             expired;
    logic             entered;
    logic             pd;
    int               idx;
    entered = 1'b0;
    pd      = 1'b0;
    if (it.op == OP_CMP) begin
      if (it.cmp_channel == CH_CC1 || it.cmp_channel == CH_CC2) begin
        idx = (it.cmp_channel == CH_CC2) ? 1 : 0;
        cc_count[idx] = cc_count[idx] + 1'b1;
        if (cc_count[idx] > cfg_shadow.debounce_limit) begin
          cc_count[idx] = '0;
          link_up       = !link_up;
          on_cc2        = (idx != 0);
        end
        watch_below   = link_up;
        arm_mask[idx] = 1'b1;
      end
    end else begin
      nxt = role_now;
      if (tmr_on && tmr_left != '0) tmr_left = tmr_left - 1'b1;
      expired = tmr_on && tmr_left == '0;
      case (role_now)
        S_IDLE: begin
          if (expired) begin
            tmr_on   = 1'b0;
            arm_mask = '0;
            nxt      = S_UNSRC;
          end
        end
        S_UNSNK: begin
          cc_count[0] = '0;
          cc_count[1] = '0;
          link_up     = 1'b0;
          watch_below = 1'b0;
          arm_mask    = 2'b11;
          tmr_left    = timer_t'(cfg_shadow.try_sink_ticks);
          tmr_on      = 1'b1;
          nxt         = S_AWSNK;
        end
        S_AWSNK: begin
          if (expired) begin
            sink_tried = 1'b1;
            nxt        = S_UNSRC;
          end
          if (link_up) nxt = S_ATSNK;
          if (nxt != S_AWSNK) tmr_on = 1'b0;
        end
        S_ATSNK: begin
          if (it.swap_done) begin
            arm_mask = '0;
            nxt      = S_ATSRC;
          end
          if (!swapping && it.swap_primary) swapping = 1'b1;
          if (!link_up && !swapping) nxt = S_UNSRC;
          if (expired) begin
            sink_tried = 1'b1;
            nxt        = S_UNSRC;
          end
          if (nxt != S_ATSNK) tmr_on = 1'b0;
        end
        S_UNSRC: begin
          if (expired) sink_tried = 1'b0;
          if (it.sink_present) nxt = sink_tried ? S_ATSRC : S_UNSNK;
          if (nxt != S_UNSRC) tmr_on = 1'b0;
        end
        S_ATSRC: begin
          if (!it.sink_present) nxt = S_UNSRC;
        end
        default: ;
      endcase
      if (nxt != role_now) begin
        role_now = nxt;
        entered  = 1'b1;
        case (nxt)
          S_ATSNK: begin
            tmr_left = timer_t'(cfg_shadow.sink_to_src_ticks);
            tmr_on   = 1'b1;
            pd       = 1'b1;
            swapping = 1'b0;
            snk_attaches++;
          end
          S_UNSRC: begin
            arm_mask = '0;
            if (sink_tried) begin
              tmr_left = timer_t'(cfg_shadow.wait_sink_ticks);
              tmr_on   = 1'b1;
            end
          end
          S_ATSRC: begin
            sink_tried = 1'b0;
            src_attaches++;
          end
          default: ;
        endcase
      end
    end
    r.role_state = role_now;
    r.rd_on      = (role_now >= S_UNSNK) && (role_now <= S_ATSNK);
    r.rp_on      = (role_now == S_UNSRC) || (role_now == S_ATSRC);
    r.cmp_armed  = arm_mask;
    r.cmp_below  = watch_below;
    r.cc2_active = on_cc2;
    r.pd_start   = pd;
    r.stay_awake = entered || (role_now < S_UNSRC);
    return r;
  endfunction

  task automatic flag(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at result %0d: %s", n_checked, msg);
  endtask

  task automatic push_beat(logic op, logic [1:0] ch, logic sp, logic sd, logic spr);
    item_t it;
    it.op           = op;
    it.cmp_channel  = ch;
    it.sink_present = sp;
    it.swap_done    = sd;
    it.swap_primary = spr;
    beat_q.push_back(it);
    n_pushed++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_DEBOUNCE_LIMIT:    cfg_shadow.debounce_limit    = data[4:0];
      REG_POWER_ON_TICKS:    cfg_shadow.power_on_ticks    = data[7:0];
      REG_TRY_SINK_TICKS:    cfg_shadow.try_sink_ticks    = data[11:0];
      REG_WAIT_SINK_TICKS:   cfg_shadow.wait_sink_ticks   = data[11:0];
      REG_SINK_TO_SRC_TICKS: cfg_shadow.sink_to_src_ticks = data[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [4:0] dl, logic [7:0] pon, logic [11:0] tt,
                            logic [11:0] wt, logic [11:0] st);
    write_reg(REG_DEBOUNCE_LIMIT, {7'($urandom), dl});
    write_reg(REG_POWER_ON_TICKS, {4'($urandom), pon});
    write_reg(REG_TRY_SINK_TICKS, tt);
    write_reg(REG_WAIT_SINK_TICKS, wt);
    write_reg(REG_SINK_TO_SRC_TICKS, st);
    write_reg(REG_SPARE + CfgIdxW'($urandom_range(0, 2)), CfgW'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    while (n_checked != n_pushed) @(posedge clk_i);
  endtask

  // mostly ticks and debounce bursts sized around the current limit, some noise
  task automatic queue_random(int n);
    int         k;
    int         sel;
    int         len;
    logic       op;
    logic [1:0] ch;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        push_beat(OP_TICK, 2'($urandom), $urandom_range(0, 99) < 75,
                  $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 12);
        k++;
      end else if (sel < 85) begin
        ch  = $urandom_range(0, 1) ? CH_CC2 : CH_CC1;
        len = $urandom_range(1, int'(cfg_shadow.debounce_limit) + 2);
        repeat (len) push_beat(OP_CMP, ch, 1'($urandom), 1'($urandom), 1'($urandom));
        k += len;
      end else begin
        op = 1'($urandom);
        ch = 2'($urandom);
        push_beat(op, ch, 1'($urandom), 1'($urandom), 1'($urandom));
        if (op == OP_TICK || ch == CH_CC1 || ch == CH_CC2) k++;
      end
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expect_q.push_back(role_step(offer_beat));
      if (!in_if.valid || in_if.ready) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer_beat         = beat_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.op           <= offer_beat.op;
          in_if.cmp_channel  <= offer_beat.cmp_channel;
          in_if.sink_present <= offer_beat.sink_present;
          in_if.swap_done    <= offer_beat.swap_done;
          in_if.swap_primary <= offer_beat.swap_primary;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long result hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expect_q.size() == 0) begin
          flag("result beat with no prediction pending");
        end else begin
          want = expect_q.pop_front();
          n_checked++;
          if (out_if.role_state !== want.role_state)
            flag($sformatf("role_state got %0h want %0h", out_if.role_state, want.role_state));
          if (out_if.rd_on !== want.rd_on)
            flag($sformatf("rd_on got %0h want %0h", out_if.rd_on, want.rd_on));
          if (out_if.rp_on !== want.rp_on)
            flag($sformatf("rp_on got %0h want %0h", out_if.rp_on, want.rp_on));
          if (out_if.cmp_armed !== want.cmp_armed)
            flag($sformatf("cmp_armed got %0h want %0h", out_if.cmp_armed, want.cmp_armed));
          if (out_if.cmp_below !== want.cmp_below)
            flag($sformatf("cmp_below got %0h want %0h", out_if.cmp_below, want.cmp_below));
          if (out_if.cc2_active !== want.cc2_active)
            flag($sformatf("cc2_active got %0h want %0h", out_if.cc2_active, want.cc2_active));
          if (out_if.pd_start !== want.pd_start)
            flag($sformatf("pd_start got %0h want %0h", out_if.pd_start, want.pd_start));
          if (out_if.stay_awake !== want.stay_awake)
            flag($sformatf("stay_awake got %0h want %0h", out_if.stay_awake, want.stay_awake));
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int          ph;
    int          n;
    logic [4:0]  dl;
    logic [7:0]  pon;
    logic [11:0] tt;
    logic [11:0] wt;
    logic [11:0] st;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_DEBOUNCE_LIMIT;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.op            = OP_TICK;
    in_if.cmp_channel   = CH_OFF0;
    in_if.sink_present  = 1'b0;
    in_if.swap_done     = 1'b0;
    in_if.swap_primary  = 1'b0;
    out_if.ready        = 1'b0;
    n_pushed            = 0;
    n_checked           = 0;
    errors              = 0;
    n_settings          = 0;
    snk_attaches        = 0;
    src_attaches        = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_req            = 0;

    cfg_shadow.debounce_limit    = RST_DEBOUNCE_LIMIT;
    cfg_shadow.power_on_ticks    = RST_POWER_ON_TICKS;
    cfg_shadow.try_sink_ticks    = RST_TRY_SINK_TICKS;
    cfg_shadow.wait_sink_ticks   = RST_WAIT_SINK_TICKS;
    cfg_shadow.sink_to_src_ticks = RST_SINK_TO_SRC_TICKS;
    role_now    = S_IDLE;
    tmr_left    = timer_t'(RST_POWER_ON_TICKS);
    tmr_on      = 1'b1;
    cc_count[0] = '0;
    cc_count[1] = '0;
    link_up     = 1'b0;
    on_cc2      = 1'b0;
    sink_tried  = 1'b0;
    swapping    = 1'b0;
    arm_mask    = '0;
    watch_below = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the roles: single-hit debounce, short timers
    set_config(5'd0, 8'd4, 12'd3, 12'd0, 12'd2);
    push_beat(OP_CMP,  CH_OFF0, 1'b1, 1'b1, 1'b1);
    push_beat(OP_CMP,  CH_OFF1, 1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_CC2,  1'b1, 1'b1, 1'b1);
    push_beat(OP_TICK, CH_OFF0, 1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b0, 1'b0, 1'b0);
    push_beat(OP_CMP,  CH_CC1,  1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b1);
    push_beat(OP_CMP,  CH_CC2,  1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_CMP,  CH_CC1,  1'b1, 1'b1, 1'b1);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b1, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_CMP,  CH_CC2,  1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);
    push_beat(OP_CMP,  CH_CC2,  1'b0, 1'b0, 1'b0);
    push_beat(OP_TICK, CH_OFF0, 1'b1, 1'b0, 1'b0);

    for (ph = 0; ph < 8; ph++) begin
      drain();
      n = BEATS_PER_PHASE;
      case (ph)
        0: begin
          dl = 5'd0; pon = 8'd0; tt = 12'd0; wt = 12'd0; st = 12'd0;
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          dl = 5'd31; pon = 8'd255; tt = 12'd4095; wt = 12'd4095; st = 12'd4095;
          send_idle_pct = 73; recv_stall_pct = 0; n = 150;
        end
        2: begin
          dl = 5'd1; pon = 8'd7; tt = 12'd5; wt = 12'd9; st = 12'd12;
          send_idle_pct = 0; recv_stall_pct = 73;
        end
        3: begin
          dl = 5'd3; pon = 8'd20; tt = 12'd30; wt = 12'd8; st = 12'd40;
          send_idle_pct = 26; recv_stall_pct = 26;
        end
        7: begin
          dl = 5'($urandom); pon = 8'($urandom);
          tt = 12'($urandom_range(0, 60)); wt = 12'($urandom_range(0, 60));
          st = 12'($urandom_range(0, 60));
          send_idle_pct = 26; recv_stall_pct = 26; n = 350;
        end
        default: begin
          dl = 5'($urandom_range(0, 4)); pon = 8'($urandom);
          tt = 12'($urandom_range(0, 24)); wt = 12'($urandom_range(0, 24));
          st = 12'($urandom_range(0, 24));
          send_idle_pct  = (ph == 5) ? 73 : 0;
          recv_stall_pct = (ph == 6) ? 73 : 0;
        end
      endcase
      set_config(dl, pon, tt, wt, st);
      if (ph == 2) hold_req <= hold_req + 1;
      queue_random(n);
    end
    drain();
    repeat (GRACE_CYCLES) @(posedge clk_i);

    $display("checked %0d result beats over %0d register settings and four idle patterns",
             n_checked, n_settings);
    $display("attached sink entered %0d times, attached source %0d times, %0d mismatches",
             snk_attaches, src_attaches, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
